FILE: rtl/arl_pkg.sv
// Package for the address region delay lookup: table size, item codes,
// channel payload types and the controller-to-datapath command group.
// No dependencies.
`timescale 1ns / 1ps

package arl_pkg;

    localparam int NUM_RULES = 16;
    localparam int IDX_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  entry_index;
        logic        entry_valid;
        logic        range_mode;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [15:0] read_delay_in;
        logic [15:0] read_drop_in;
        logic [15:0] write_delay_in;
        logic [15:0] write_drop_in;
        logic [31:0] address;
        logic        is_read;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] delay_cycles;
        logic [15:0] drop_delay_cycles;
        logic [3:0]  matched_entry;
    } out_item_t;

    typedef struct packed {
        logic wr_en;    // store the rule carried by the input item
        logic cap_en;   // register the per-rule match vector
        logic out_load; // resolve priority and load the result register
    } arl_cmd_t;

endpackage

FILE: rtl/arl_ctrl.sv
// Controller for the address region delay lookup: handshake and sequencing.
// Depends on arl_pkg.
`timescale 1ns / 1ps

module arl_ctrl
    import arl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_func,
    output logic     m_valid,
    input  logic     m_ready,
    output arl_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   s_accept;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd.wr_en    = s_accept && (s_func == FUNC_WRITE);
        cmd.cap_en   = s_accept && (s_func == FUNC_LOOKUP);
        // result register must be free or draining this cycle
        cmd.out_load = (state_reg == ST_RESOLVE) && (!m_valid_reg || m_ready);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.cap_en) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                if (cmd.out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/arl_datapath.sv
// Datapath for the address region delay lookup: rule table, parallel
// comparators, priority encoder and result register. Depends on arl_pkg.
`timescale 1ns / 1ps

module arl_datapath
    import arl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  arl_cmd_t  cmd,
    input  in_item_t  s_data,
    output out_item_t m_data
);

    logic [NUM_RULES-1:0] valid_reg;
    logic [NUM_RULES-1:0] range_reg;
    logic [31:0]          first_reg  [NUM_RULES];
    logic [31:0]          second_reg [NUM_RULES];
    logic [15:0]          rd_dly_reg   [NUM_RULES];
    logic [15:0]          rd_drop_reg  [NUM_RULES];
    logic [15:0]          wr_dly_reg   [NUM_RULES];
    logic [15:0]          wr_drop_reg  [NUM_RULES];

    logic [NUM_RULES-1:0] match_vec;
    logic [NUM_RULES-1:0] match_reg;
    logic                 is_read_reg;

    logic                 slot_ok;
    logic [IDX_W-1:0]     wr_slot;
    logic                 found;
    logic [IDX_W-1:0]     sel;
    out_item_t            out_reg, out_next;

    assign slot_ok = ({28'd0, s_data.entry_index} < 32'(NUM_RULES));
    assign wr_slot = IDX_W'(s_data.entry_index);

    // valid bits are the only table state cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.wr_en && slot_ok) begin
            valid_reg[wr_slot] <= s_data.entry_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && slot_ok) begin
            range_reg[wr_slot]    <= s_data.range_mode;
            first_reg[wr_slot]    <= s_data.first_word;
            // mask rules keep the match already masked
            second_reg[wr_slot]   <= s_data.range_mode ? s_data.second_word
                                   : (s_data.second_word & s_data.first_word);
            rd_dly_reg[wr_slot]   <= s_data.read_delay_in;
            rd_drop_reg[wr_slot]  <= s_data.read_drop_in;
            wr_dly_reg[wr_slot]   <= s_data.write_delay_in;
            wr_drop_reg[wr_slot]  <= s_data.write_drop_in;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_RULES; i++) begin
            if (range_reg[i]) begin
                match_vec[i] = valid_reg[i] && (first_reg[i] <= s_data.address)
                               && (s_data.address <= second_reg[i]);
            end else begin
                match_vec[i] = valid_reg[i]
                               && ((first_reg[i] & s_data.address) == second_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            match_reg   <= match_vec;
            is_read_reg <= s_data.is_read;
        end
    end

    // lowest index wins
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = NUM_RULES - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                found = 1'b1;
                sel   = IDX_W'(i);
            end
        end

        out_next = '0;
        if (found) begin
            out_next.hit           = 1'b1;
            out_next.matched_entry = 4'(sel);
            if (is_read_reg) begin
                out_next.delay_cycles      = rd_dly_reg[sel];
                out_next.drop_delay_cycles = rd_drop_reg[sel];
            end else begin
                out_next.delay_cycles      = wr_dly_reg[sel];
                out_next.drop_delay_cycles = wr_drop_reg[sel];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

FILE: rtl/address_region_delay_lookup_top.sv
// Channel   | Ports                        | Carries
// ----------+------------------------------+-------------------------------
// input     | s_valid, s_ready, s_data     | rule write or address lookup
// result    | m_valid, m_ready, m_data     | hit, delays, matched index
//
// A rule write is stored when it is accepted and gives no result. In a lookup,
// the rule comparators first feed a match register, then the priority
// encoder and delay select load the result register; the next item is taken
// in the cycle after that. Synchronous active-low reset clears the valid
// bits and handshake state. A stalled result holds the lookup in its resolve
// state until the result register drains; writes are accepted meanwhile only
// once the lookup has moved on. Depends on arl_pkg, arl_ctrl, arl_datapath.
`timescale 1ns / 1ps

module address_region_delay_lookup_top
    import arl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    arl_cmd_t cmd;

    arl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    arl_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

FILE: sim/tb_top.sv
// Testbench for address_region_delay_lookup_top: directed and random rule writes and lookups,
// checked against a scoreboard that mirrors the rule table. Depends on arl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import arl_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 60;

    // Mirror of the rule table plus the queue of lookup results still owed by the block.
    class lookup_scoreboard;
        bit        rule_valid [NUM_RULES];
        bit        rule_range [NUM_RULES];
        bit [31:0] rule_first [NUM_RULES];
        bit [31:0] rule_second[NUM_RULES];
        bit [15:0] rule_rd_dly[NUM_RULES];
        bit [15:0] rd_drop    [NUM_RULES];
        bit [15:0] rule_wr_dly[NUM_RULES];
        bit [15:0] wr_drop    [NUM_RULES];
        out_item_t owed[$];
        int        errors;

        function void note_input(in_item_t it);
            out_item_t exp;
            int k;
            bit m;
            if (it.func == FUNC_WRITE) begin
                k = int'(it.entry_index);
                if (k < NUM_RULES) begin
                    rule_valid[k]  = it.entry_valid;
                    rule_range[k]  = it.range_mode;
                    rule_first[k]  = it.first_word;
                    // mask rules keep only the match bits covered by the mask
                    rule_second[k] = it.range_mode ? it.second_word
                                                   : (it.second_word & it.first_word);
                    rule_rd_dly[k] = it.read_delay_in;
                    rd_drop[k]     = it.read_drop_in;
                    rule_wr_dly[k] = it.write_delay_in;
                    wr_drop[k]     = it.write_drop_in;
                end
            end else begin
                exp = '0;
                for (k = 0; k < NUM_RULES; k++) begin
                    if (rule_range[k])
                        m = (rule_first[k] <= it.address) && (it.address <= rule_second[k]);
                    else
                        m = ((rule_first[k] & it.address) == rule_second[k]);
                    if (rule_valid[k] && m) begin
                        exp.hit               = 1'b1;
                        exp.delay_cycles      = it.is_read ? rule_rd_dly[k] : rule_wr_dly[k];
                        exp.drop_delay_cycles = it.is_read ? rd_drop[k]  : wr_drop[k];
                        exp.matched_entry     = k[3:0];
                        break;
                    end
                end
                owed.push_back(exp);
            end
        endfunction

        function void report(string what, logic [31:0] e, logic [31:0] a);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h actual %h", $realtime, what, e, a);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none actual %h", $realtime, got);
                return;
            end
            exp = owed.pop_front();
            if (got.hit !== exp.hit)
                report("hit", 32'(exp.hit), 32'(got.hit));
            if (got.delay_cycles !== exp.delay_cycles)
                report("delay_cycles", 32'(exp.delay_cycles), 32'(got.delay_cycles));
            if (got.drop_delay_cycles !== exp.drop_delay_cycles)
                report("drop_delay_cycles", 32'(exp.drop_delay_cycles),
                       32'(got.drop_delay_cycles));
            if (got.matched_entry !== exp.matched_entry)
                report("matched_entry", 32'(exp.matched_entry), 32'(got.matched_entry));
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    lookup_scoreboard sb;
    int  snd_idle;
    int  rcv_idle;
    bit  hold_req;
    int  hold_left;
    int  cycle_count;

    address_region_delay_lookup_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: check accepted items, then choose ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
        if (hold_req) begin
            hold_left = 300;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // every field random, so fields the item does not use still toggle
    function automatic in_item_t noise_item();
        in_item_t it;
        it.func           = 1'($urandom_range(1));
        it.entry_index    = 4'($urandom_range(15));
        it.entry_valid    = 1'($urandom_range(1));
        it.range_mode     = 1'($urandom_range(1));
        it.first_word     = $urandom;
        it.second_word    = $urandom;
        it.read_delay_in  = 16'($urandom);
        it.read_drop_in   = 16'($urandom);
        it.write_delay_in = 16'($urandom);
        it.write_drop_in  = 16'($urandom);
        it.address        = $urandom;
        it.is_read        = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic in_item_t rule_item(bit [3:0] idx, bit vld, bit rng,
                                           bit [31:0] w1, bit [31:0] w2,
                                           bit [15:0] rdl, bit [15:0] rdr,
                                           bit [15:0] wdl, bit [15:0] wdr);
        in_item_t it;
        it = noise_item();
        it.func           = FUNC_WRITE;
        it.entry_index    = idx;
        it.entry_valid    = vld;
        it.range_mode     = rng;
        it.first_word     = w1;
        it.second_word    = w2;
        it.read_delay_in  = rdl;
        it.read_drop_in   = rdr;
        it.write_delay_in = wdl;
        it.write_drop_in  = wdr;
        return it;
    endfunction

    function automatic in_item_t lookup_item(bit [31:0] addr, bit rd);
        in_item_t it;
        it = noise_item();
        it.func    = FUNC_LOOKUP;
        it.address = addr;
        it.is_read = rd;
        return it;
    endfunction

    // random rule write, mostly with sensible regions
    function automatic in_item_t random_rule();
        bit [31:0] w1;
        bit [31:0] w2;
        bit [32:0] sum;
        bit rng;
        rng = 1'($urandom_range(1));
        w1  = $urandom;
        w2  = $urandom;
        if (rng) begin
            case ($urandom_range(3))
                0, 1: begin
                    sum = {1'b0, w1} + 33'($urandom_range(4096));
                    w2  = sum[32] ? 32'hffff_ffff : sum[31:0];
                end
                2: ;    // random end, often an empty range
                default: if ($urandom_range(1)) w1 = '0; else w2 = '1;
            endcase
        end else if ($urandom_range(1)) begin
            w1 = 32'hffff_ffff << $urandom_range(32);
        end
        return rule_item(4'($urandom_range(15)), $urandom_range(99) < 85, rng, w1, w2,
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    // lookup aimed at the region held in a random slot, or a random address
    function automatic in_item_t random_lookup();
        int k;
        bit [31:0] a;
        bit [31:0] lo;
        bit [31:0] hi;
        bit [32:0] span;
        k = int'($urandom_range(NUM_RULES - 1));
        lo = sb.rule_first[k];
        hi = sb.rule_second[k];
        a  = $urandom;
        if ($urandom_range(99) < 75) begin
            if (sb.rule_range[k]) begin
                case ($urandom_range(4))
                    0: a = lo;
                    1: a = hi;
                    2: a = lo - 32'd1;
                    3: a = hi + 32'd1;
                    default: if (hi >= lo) begin
                        span = {1'b0, hi} - {1'b0, lo} + 33'd1;
                        a = lo + 32'({$urandom, $urandom} % span);
                    end
                endcase
            end else begin
                a = hi | (a & ~lo);
                if ($urandom_range(3) == 0)
                    a = a ^ (32'h1 << $urandom_range(31));
            end
        end
        return lookup_item(a, 1'($urandom_range(1)));
    endfunction

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(it);
    endtask

    task automatic random_phase(int n);
        repeat (n) begin
            if ($urandom_range(99) < 30) send_item(random_rule());
            else send_item(random_lookup());
        end
    endtask

    initial begin
        sb          = new();
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        snd_idle    = 0;
        rcv_idle    = 0;
        hold_req    = 1'b0;
        hold_left   = 0;
        cycle_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, catch-all mask, ranges, priority, empty range, removal
        send_item(lookup_item(32'h0000_0000, 1'b1));
        send_item(lookup_item(32'hffff_ffff, 1'b0));
        send_item(rule_item(4'd15, 1, 0, 32'h0, 32'hffff_ffff,
                            16'hffff, 16'hffff, 16'h0, 16'h0));
        send_item(lookup_item(32'h0000_0000, 1'b1));
        send_item(lookup_item(32'hffff_ffff, 1'b0));
        send_item(rule_item(4'd0, 1, 1, 32'h0000_1000, 32'h0000_1fff,
                            16'd1, 16'd2, 16'd3, 16'd4));
        send_item(lookup_item(32'h0000_1000, 1'b1));
        send_item(lookup_item(32'h0000_1fff, 1'b0));
        send_item(lookup_item(32'h0000_0fff, 1'b1));
        send_item(lookup_item(32'h0000_2000, 1'b0));
        send_item(rule_item(4'd1, 1, 1, 32'h0000_5000, 32'h0000_4000,
                            16'd5, 16'd6, 16'd7, 16'd8));
        send_item(lookup_item(32'h0000_4800, 1'b1));
        // match bits outside the mask must not block the hit
        send_item(rule_item(4'd2, 1, 0, 32'hffff_0000, 32'habcd_1234,
                            16'h0102, 16'h0304, 16'h0506, 16'h0708));
        send_item(lookup_item(32'habcd_5678, 1'b0));
        send_item(rule_item(4'd3, 1, 1, 32'h0, 32'hffff_ffff,
                            16'h8000, 16'h7fff, 16'h00ff, 16'hff00));
        send_item(lookup_item(32'h0000_1500, 1'b1));
        send_item(lookup_item(32'h0000_0009, 1'b0));
        send_item(rule_item(4'd0, 0, 1, 32'h0000_1000, 32'h0000_1fff,
                            16'd1, 16'd2, 16'd3, 16'd4));
        send_item(lookup_item(32'h0000_1500, 1'b1));
        send_item(rule_item(4'd4, 1, 0, 32'hffff_ffff, 32'h1234_5678,
                            16'h1111, 16'h2222, 16'h3333, 16'h4444));
        send_item(rule_item(4'd3, 0, 1, 32'h0, 32'hffff_ffff, 16'h0, 16'h0, 16'h0, 16'h0));
        send_item(rule_item(4'd15, 0, 0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0));
        send_item(lookup_item(32'h1234_5678, 1'b0));
        send_item(lookup_item(32'h1234_5679, 1'b1));

        snd_idle = 32;
        rcv_idle = 88;
        random_phase(500);

        snd_idle = 88;
        rcv_idle = 32;
        random_phase(500);

        snd_idle = 0;
        rcv_idle = 0;
        // long receiver stall with the sender still offering items
        hold_req = 1'b1;
        repeat (40) send_item(random_lookup());
        random_phase(500);

        s_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
